// ===== src/pld_pkg.sv =====
`timescale 1ns / 1ps
// shared widths and types for the point-line distance pipeline
// no dependencies; used by pld_sqrt, point_line_distance and the test files
package pld_pkg;

  localparam int IN_W   = 32;          // width of every input coordinate port
  localparam int FRAC_W = 32;          // fractional bits of the projection scale t
  localparam int DSQ_W  = 64;          // squared distance, unsigned q32.32
  localparam int ROOT_W = DSQ_W / 2;   // bits of the floor square root
  localparam int DIST_W = 48;          // distance port width

  typedef logic [DSQ_W-1:0]  dsq_t;
  typedef logic [ROOT_W-1:0] root_t;

endpackage

// ===== src/pld_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, with sideband
// standalone; used by point_line_distance
module pld_div #(
  parameter int DW = 64,
  parameter int QW = 65,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [DW-1:0] rem_init,
  input  logic [QW-1:0] num,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] side,
  output logic          out_vld,
  output logic [QW-1:0] quot,
  output logic [SW-1:0] side_out
);

  logic          vld_q [QW];
  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] nq_q  [QW];   // numerator bits shift out, quotient bits shift in
  logic [DW-1:0] dv_q  [QW];
  logic [SW-1:0] sd_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic          vld_i;
    logic [DW-1:0] rem_i;
    logic [DW-1:0] dv_i;
    logic [QW-1:0] nq_i;
    logic [SW-1:0] sd_i;
    logic [DW:0]   cand;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_i = in_vld;
      assign rem_i = rem_init;
      assign dv_i  = divisor;
      assign nq_i  = num;
      assign sd_i  = side;
    end else begin : g_next
      assign vld_i = vld_q[k-1];
      assign rem_i = rem_q[k-1];
      assign dv_i  = dv_q[k-1];
      assign nq_i  = nq_q[k-1];
      assign sd_i  = sd_q[k-1];
    end

    assign cand = {rem_i, nq_i[QW-1]};
    assign diff = cand - {1'b0, dv_i};
    assign ge   = (cand >= {1'b0, dv_i});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? diff[DW-1:0] : cand[DW-1:0];
        nq_q[k]  <= {nq_i[QW-2:0], ge};
        dv_q[k]  <= dv_i;
        sd_q[k]  <= sd_i;
      end
    end
  end

  assign out_vld  = vld_q[QW-1];
  assign quot     = nq_q[QW-1];
  assign side_out = sd_q[QW-1];

endmodule

// ===== src/pld_sqrt.sv =====
`timescale 1ns / 1ps
// pipelined floor square root, one root bit per stage, with sideband
// depends on pld_pkg for the default radicand width
module pld_sqrt #(
  parameter int XW = pld_pkg::DSQ_W,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [XW-1:0]     radicand,
  input  logic [SW-1:0]     side,
  output logic              out_vld,
  output logic [XW/2-1:0]   root,
  output logic [SW-1:0]     side_out
);

  localparam int RW  = XW / 2;
  localparam int RMW = RW + 2;

  logic           vld_q  [RW];
  logic [RMW-1:0] rem_q  [RW];
  logic [XW-1:0]  x_q    [RW];
  logic [RW-1:0]  root_q [RW];
  logic [SW-1:0]  sd_q   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic           vld_i;
    logic [RMW-1:0] rem_i;
    logic [XW-1:0]  x_i;
    logic [RW-1:0]  root_i;
    logic [SW-1:0]  sd_i;
    logic [RMW+1:0] cand;
    logic [RMW+1:0] trial;
    logic [RMW+1:0] diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = '0;
      assign x_i    = radicand;
      assign root_i = '0;
      assign sd_i   = side;
    end else begin : g_next
      assign vld_i  = vld_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign x_i    = x_q[k-1];
      assign root_i = root_q[k-1];
      assign sd_i   = sd_q[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign cand  = {rem_i, x_i[XW-1:XW-2]};
    assign trial = {2'b00, root_i, 2'b01};
    assign diff  = cand - trial;
    assign ge    = (cand >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? diff[RMW-1:0] : cand[RMW-1:0];
        x_q[k]    <= {x_i[XW-3:0], 2'b00};
        root_q[k] <= {root_i[RW-2:0], ge};
        sd_q[k]   <= sd_i;
      end
    end
  end

  assign out_vld  = vld_q[RW-1];
  assign root     = root_q[RW-1];
  assign side_out = sd_q[RW-1];

endmodule

// ===== src/point_line_distance.sv =====
`timescale 1ns / 1ps
// point to line distance in 3d: top level with input, projection and output stages
// depends on pld_pkg, pld_div and pld_sqrt
//
// usage
//   input channel: in_valid / in_ready with point, line origin and line direction,
//   each component signed q16.16 (low COORD_WIDTH bits used, sign-extended)
//   output channel: out_valid / out_ready with distance_squared (unsigned q32.32,
//   saturating), distance (floor root, q16.16) and degenerate (zero direction,
//   projection scale forced to zero)
//   throughput: one transfer per cycle while the skid entry is empty; every step is its own register stage:
//   the divider makes one quotient bit per stage (COORD_WIDTH + 33 stages)
//   and the root unit one root bit per stage (32 stages)
//   stall: an output register plus one skid entry; while the skid entry is
//   full in_ready is low and the whole pipeline holds its contents
//   reset: clears all stage valid bits, the output and the skid entry
module point_line_distance #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [pld_pkg::IN_W-1:0]   point_x,
  input  logic signed [pld_pkg::IN_W-1:0]   point_y,
  input  logic signed [pld_pkg::IN_W-1:0]   point_z,
  input  logic signed [pld_pkg::IN_W-1:0]   origin_x,
  input  logic signed [pld_pkg::IN_W-1:0]   origin_y,
  input  logic signed [pld_pkg::IN_W-1:0]   origin_z,
  input  logic signed [pld_pkg::IN_W-1:0]   dir_x,
  input  logic signed [pld_pkg::IN_W-1:0]   dir_y,
  input  logic signed [pld_pkg::IN_W-1:0]   dir_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pld_pkg::DSQ_W-1:0]         distance_squared,
  output logic [pld_pkg::DIST_W-1:0]        distance,
  output logic                              degenerate
);

  import pld_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int UW   = W + 1;            // u = p - p0, signed
  localparam int PW   = 2 * W;            // |u|*|d| and |d|^2 products
  localparam int UDSW = 2 * W + 2;        // signed dot product u.d
  localparam int UDW  = 2 * W + 1;        // |u.d|
  localparam int DDW  = 2 * W;            // d.d
  localparam int QW   = W + FRAC_W + 1;   // t, bounded by |u| * 2^32
  localparam int HW   = QW - W;           // upper slice of t
  localparam int PJW  = W + 2;            // projected component magnitude
  localparam int VW   = W + 3;            // v = u - t*d, signed
  localparam int SQW  = 2 * VW;           // v^2
  localparam int SUMW = (SQW + 2 > DSQ_W + 1) ? SQW + 2 : DSQ_W + 1;

  typedef struct packed {
    logic [2:0][UW-1:0] u;
    logic [2:0][W-1:0]  dm;
    logic [2:0]         ds;
    logic               neg;
    logic               deg;
  } dside_t;

  typedef struct packed {
    dsq_t dsq;
    logic deg;
  } rside_t;

  // global advance: the pipeline holds only while the skid entry is occupied
  logic en;
  logic skid_valid;
  assign en       = !skid_valid;
  assign in_ready = en;

  logic [2:0][IN_W-1:0] pt, og, dr;
  assign pt = {point_z, point_y, point_x};
  assign og = {origin_z, origin_y, origin_x};
  assign dr = {dir_z, dir_y, dir_x};

  // stage 1: sign-extend from the coordinate width, u = p - p0
  logic               s1_vld;
  logic [2:0][UW-1:0] s1_u;
  logic [2:0][W-1:0]  s1_d;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_u[i] <= {pt[i][W-1], pt[i][W-1:0]} - {og[i][W-1], og[i][W-1:0]};
        s1_d[i] <= dr[i][W-1:0];
      end
    end
  end

  // stage 2: magnitudes and signs
  logic [2:0][UW-1:0] s1_un;
  logic [2:0][W-1:0]  s1_dn;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_un[i] = UW'(0) - s1_u[i];
      s1_dn[i] = W'(0) - s1_d[i];
    end
  end

  logic               s2_vld;
  logic [2:0][UW-1:0] s2_u;
  logic [2:0][W-1:0]  s2_um, s2_dm;
  logic [2:0]         s2_us, s2_ds;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_u[i]  <= s1_u[i];
        s2_us[i] <= s1_u[i][UW-1];
        s2_ds[i] <= s1_d[i][W-1];
        s2_um[i] <= s1_u[i][UW-1] ? s1_un[i][W-1:0] : s1_u[i][W-1:0];
        s2_dm[i] <= s1_d[i][W-1] ? s1_dn[i] : s1_d[i];
      end
    end
  end

  // stage 3: per-lane products for u.d and d.d
  logic               s3_vld;
  logic [2:0][UW-1:0] s3_u;
  logic [2:0][W-1:0]  s3_dm;
  logic [2:0]         s3_ds, s3_ps;
  logic [2:0][PW-1:0] s3_p, s3_q;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s3_p[i] <= s2_um[i] * s2_dm[i];
        s3_q[i] <= s2_dm[i] * s2_dm[i];
        s3_ps[i] <= s2_us[i] ^ s2_ds[i];
      end
      s3_u  <= s2_u;
      s3_dm <= s2_dm;
      s3_ds <= s2_ds;
    end
  end

  // stage 4: dot products
  logic [UDSW-1:0] ud_sum;
  logic [DDW+1:0]  dd_sum;
  always_comb begin
    ud_sum = '0;
    dd_sum = '0;
    for (int i = 0; i < 3; i++) begin
      ud_sum = s3_ps[i] ? ud_sum - {2'b00, s3_p[i]} : ud_sum + {2'b00, s3_p[i]};
      dd_sum = dd_sum + {2'b00, s3_q[i]};
    end
  end

  logic               s4_vld;
  logic [2:0][UW-1:0] s4_u;
  logic [2:0][W-1:0]  s4_dm;
  logic [2:0]         s4_ds;
  logic [UDSW-1:0]    s4_ud;
  logic [DDW-1:0]     s4_dd;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ud <= ud_sum;
      s4_dd <= dd_sum[DDW-1:0];
      s4_u  <= s3_u;
      s4_dm <= s3_dm;
      s4_ds <= s3_ds;
    end
  end

  // stage 5: sign and magnitude of u.d, zero-direction detect
  logic [UDSW-1:0] s4_udn;
  assign s4_udn = UDSW'(0) - s4_ud;

  logic           s5_vld;
  logic [UDW-1:0] s5_udm;
  logic [DDW-1:0] s5_dd;
  dside_t         s5_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_udm       <= s4_ud[UDSW-1] ? s4_udn[UDW-1:0] : s4_ud[UDW-1:0];
      s5_dd        <= s4_dd;
      s5_side.u    <= s4_u;
      s5_side.dm   <= s4_dm;
      s5_side.ds   <= s4_ds;
      s5_side.neg  <= s4_ud[UDSW-1];
      s5_side.deg  <= (s4_dd == '0);
    end
  end

  // t = (|u.d| << 32) / d.d; the top bits of the numerator start as the
  // remainder since the quotient is known to fit QW bits
  logic           dv_vld;
  logic [QW-1:0]  dv_quot;
  dside_t         dv_side;

  pld_div #(
    .DW (DDW),
    .QW (QW),
    .SW ($bits(dside_t))
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s5_vld),
    .rem_init ({{(DDW-W){1'b0}}, s5_udm[UDW-1:W+1]}),
    .num      ({s5_udm[W:0], {FRAC_W{1'b0}}}),
    .divisor  (s5_dd),
    .side     (s5_side),
    .out_vld  (dv_vld),
    .quot     (dv_quot),
    .side_out (dv_side)
  );

  logic [QW-1:0] t;
  assign t = dv_side.deg ? '0 : dv_quot;

  // p1: t*|d| as two partial products per lane
  logic                  p1_vld;
  logic [2:0][PW-1:0]    p1_lo;
  logic [2:0][HW+W-1:0]  p1_hi;
  logic [2:0][UW-1:0]    p1_u;
  logic [2:0]            p1_ds;
  logic                  p1_neg, p1_deg;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_lo[i] <= t[W-1:0] * dv_side.dm[i];
        p1_hi[i] <= t[QW-1:W] * dv_side.dm[i];
      end
      p1_u   <= dv_side.u;
      p1_ds  <= dv_side.ds;
      p1_neg <= dv_side.neg;
      p1_deg <= dv_side.deg;
    end
  end

  // p2: join partials, drop the 32 fraction bits of t
  logic [2:0][QW+W-1:0] prod;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = {p1_hi[i], {W{1'b0}}} + {{(QW-W){1'b0}}, p1_lo[i]};
    end
  end

  logic               p2_vld;
  logic [2:0][PJW-1:0] p2_proj;
  logic [2:0]         p2_pn;
  logic [2:0][UW-1:0] p2_u;
  logic               p2_deg;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p2_proj[i] <= prod[i][FRAC_W+PJW-1:FRAC_W];
        p2_pn[i]   <= p1_neg ^ p1_ds[i];
      end
      p2_u   <= p1_u;
      p2_deg <= p1_deg;
    end
  end

  // p3: v = u - t*d with the projection sign applied
  logic [2:0][VW-1:0] ue, pe;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ue[i] = {{(VW-UW){p2_u[i][UW-1]}}, p2_u[i]};
      pe[i] = {1'b0, p2_proj[i]};
    end
  end

  logic               p3_vld;
  logic [2:0][VW-1:0] p3_v;
  logic               p3_deg;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p3_v[i] <= p2_pn[i] ? ue[i] + pe[i] : ue[i] - pe[i];
      end
      p3_deg <= p2_deg;
    end
  end

  // p4: squares
  logic                p4_vld;
  logic [2:0][SQW-1:0] p4_sq;
  logic                p4_deg;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p4_sq[i] <= $signed(p3_v[i]) * $signed(p3_v[i]);
      end
      p4_deg <= p3_deg;
    end
  end

  // p5: sum of squares, saturate to q32.32
  logic [SUMW-1:0] sq_sum;
  assign sq_sum = {{(SUMW-SQW){1'b0}}, p4_sq[0]} + {{(SUMW-SQW){1'b0}}, p4_sq[1]}
                + {{(SUMW-SQW){1'b0}}, p4_sq[2]};

  logic   p5_vld;
  rside_t p5_side;

  always_ff @(posedge clk) begin
    if (en) begin
      p5_side.dsq <= (|sq_sum[SUMW-1:DSQ_W]) ? '1 : sq_sum[DSQ_W-1:0];
      p5_side.deg <= p4_deg;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      p4_vld <= 1'b0;
      p5_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      p1_vld <= dv_vld;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      p4_vld <= p3_vld;
      p5_vld <= p4_vld;
    end
  end

  // floor square root of the saturated sum
  logic   rt_vld;
  root_t  rt_root;
  rside_t rt_side;

  pld_sqrt #(
    .XW (DSQ_W),
    .SW ($bits(rside_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (p5_vld),
    .radicand (p5_side.dsq),
    .side     (p5_side),
    .out_vld  (rt_vld),
    .root     (rt_root),
    .side_out (rt_side)
  );

  // output register and skid entry
  dsq_t  skid_dsq;
  root_t skid_root;
  logic  skid_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (rt_vld) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        distance_squared <= skid_dsq;
        distance         <= {{(DIST_W-ROOT_W){1'b0}}, skid_root};
        degenerate       <= skid_deg;
      end
    end else if (rt_vld) begin
      if (!out_valid || out_ready) begin
        distance_squared <= rt_side.dsq;
        distance         <= {{(DIST_W-ROOT_W){1'b0}}, rt_root};
        degenerate       <= rt_side.deg;
      end else begin
        skid_dsq  <= rt_side.dsq;
        skid_root <= rt_root;
        skid_deg  <= rt_side.deg;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // the skid entry is only ever used behind a full output register
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  // the skid entry fills only when the output is held by the receiver
  a_skid_fill : assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid entry filled without a receiver stall");

  // distance is the floor root: its square does not exceed the squared distance
  a_root_low : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (97'(distance) * 97'(distance) <= 97'(distance_squared)))
    else $error("distance too large for distance_squared");

  // and the next value up squares past it
  a_root_high : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((97'(distance) + 97'd1) * (97'(distance) + 97'd1)
                   > 97'(distance_squared)))
    else $error("distance too small for distance_squared");
`endif

endmodule

// ===== test/pld_checker.sv =====
`timescale 1ns / 1ps
// checker for the point-line distance block: watches both channels, predicts, compares
// depends on pld_pkg
module pld_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic signed [pld_pkg::IN_W-1:0] point_x,
  input  logic signed [pld_pkg::IN_W-1:0] point_y,
  input  logic signed [pld_pkg::IN_W-1:0] point_z,
  input  logic signed [pld_pkg::IN_W-1:0] origin_x,
  input  logic signed [pld_pkg::IN_W-1:0] origin_y,
  input  logic signed [pld_pkg::IN_W-1:0] origin_z,
  input  logic signed [pld_pkg::IN_W-1:0] dir_x,
  input  logic signed [pld_pkg::IN_W-1:0] dir_y,
  input  logic signed [pld_pkg::IN_W-1:0] dir_z,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [pld_pkg::DSQ_W-1:0]       distance_squared,
  input  logic [pld_pkg::DIST_W-1:0]      distance,
  input  logic                            degenerate,
  output int                              fail_count,
  output int                              pending
);
  import pld_pkg::*;

  typedef struct packed {
    logic [DSQ_W-1:0]  dsq;
    logic [DIST_W-1:0] root;
    logic              degen;
  } dist_result_t;

  dist_result_t expected_q[$];

  function automatic logic [31:0] floor_root(input logic [63:0] x);
    logic [63:0] res, bit_v, rem;
    res = 0;
    rem = x;
    bit_v = 64'd1 << 62;
    while (bit_v > rem) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res[31:0];
  endfunction

  // exact wide signed arithmetic; t truncates toward zero on magnitude
  function automatic dist_result_t project_distance(
    input logic signed [31:0] p[3], input logic signed [31:0] o[3],
    input logic signed [31:0] d[3]);
    logic signed [63:0]  u[3], dv[3], vv[3];
    logic signed [159:0] ud, tproj;
    logic [127:0]        dd, sq;
    logic [191:0]        num, tmag;
    logic                neg_t;
    dist_result_t        r;
    ud = 0;
    dd = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      u[i]  = 64'(p[i]) - 64'(o[i]);
      dv[i] = 64'(d[i]);
      ud = ud + 160'(u[i]) * 160'(dv[i]);
      dd = dd + 128'(dv[i] * dv[i]);
    end
    r.degen = (dd == 0);
    tmag = 0;
    neg_t = 0;
    if (!r.degen) begin
      neg_t = ud < 0;
      num = 192'(neg_t ? -ud : ud) << 32;
      tmag = num / 192'(dd);
    end
    for (int i = 0; i < 3; i++) begin
      tproj = 160'((tmag * 192'(dv[i] < 0 ? -dv[i] : dv[i])) >> 32);
      if (neg_t != (dv[i] < 0)) tproj = -tproj;
      vv[i] = u[i] - 64'(tproj);
      sq = sq + 128'(vv[i]) * 128'(vv[i]);
    end
    r.dsq  = (sq[127:64] != 0) ? {DSQ_W{1'b1}} : sq[63:0];
    r.root = DIST_W'(floor_root(r.dsq));
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    dist_result_t got, want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_q.push_back(project_distance('{point_x, point_y, point_z},
          '{origin_x, origin_y, origin_z}, '{dir_x, dir_y, dir_z}));
      if (out_valid && out_ready) begin
        got = '{distance_squared, distance, degenerate};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch dsq exp %h act %h, dist exp %h act %h, degen exp %b act %b",
              $time, want.dsq, got.dsq, want.root, got.root, want.degen, got.degen);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for the point-line distance block
// depends on pld_pkg, pld_checker and the block itself
module tb_top;
  import pld_pkg::*;

  localparam int N_RANDOM = 240;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0, degenerate;
  logic signed [IN_W-1:0] point_x = 0, point_y = 0, point_z = 0;
  logic signed [IN_W-1:0] origin_x = 0, origin_y = 0, origin_z = 0;
  logic signed [IN_W-1:0] dir_x = 0, dir_y = 0, dir_z = 0;
  logic [DSQ_W-1:0]  distance_squared;
  logic [DIST_W-1:0] distance;
  int fail_count, pending;
  bit  sink_calm = 0;   // no receiver idling in the last part of the run
  bit  hold_sink = 0;   // long receiver hold-off to fill the pipeline

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  point_line_distance dut (.*);
  pld_checker chk (.*);

  // receiver: bursts of stall, stretches of none
  initial begin
    int gap;
    out_ready <= 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_sink) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        hold_sink = 0;
      end
      out_ready <= 1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!sink_calm && $urandom_range(0, 2) != 0) begin
        gap = $urandom_range(1, 10);
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // random coordinate, often small so projections are meaningful
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      3: return 32'($signed($urandom_range(0, 20)) - 10);
      default: return 32'($signed($urandom() >> 8) - 32'sh0080_0000);
    endcase
  endfunction

  // offer one item and hold it until the transfer
  task automatic send_item(input logic [31:0] c[9]);
    point_x  <= c[0]; point_y  <= c[1]; point_z  <= c[2];
    origin_x <= c[3]; origin_y <= c[4]; origin_z <= c[5];
    dir_x    <= c[6]; dir_y    <= c[7]; dir_z    <= c[8];
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic maybe_idle(input bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  initial begin
    logic [31:0] c[9];
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: zero direction, extremes, on-line point, saturation
    c = '{default: 0};                                     send_item(c);
    c = '{32'h0001_0000, 2, 3, 0, 0, 0, 0, 0, 0};          send_item(c);
    c = '{default: 32'h8000_0000};                         send_item(c);
    c = '{default: 32'h7fff_ffff};                         send_item(c);
    c = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0}; send_item(c);
    c = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
          32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
          32'h0001_0000, 0, 0};                            send_item(c);
    c = '{32'h0005_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0}; send_item(c);
    c = '{0, 32'h0003_0000, 0, 0, 0, 0, 32'hffff_0000, 0, 0}; send_item(c);
    c = '{1, 1, 1, 0, 0, 0, 1, 1, 1};                      send_item(c);
    c = '{32'h1234_5678, 32'hfedc_ba98, 32'h0bad_f00d,
          32'h8000_0000, 32'h7fff_ffff, 0,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000};    send_item(c);
    c = '{32'hffff_ffff, 0, 32'h7fff_ffff, 1, 0, 32'h8000_0000,
          32'h7fff_ffff, 32'h8000_0000, 1};                send_item(c);

    // fill the pipeline while the receiver holds off
    hold_sink = 1;
    for (int n = 0; n < 150; n++) begin
      foreach (c[k]) c[k] = pick_coord();
      send_item(c);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      foreach (c[k]) c[k] = pick_coord();
      if ($urandom_range(0, 9) == 0) {c[6], c[7], c[8]} = '0;
      if (n > N_RANDOM - 80) sink_calm = 1;
      send_item(c);
      maybe_idle(!sink_calm);
    end
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
